// ===== sv/pose_settling_detector_defines.svh =====
// Assertion macros for the pose settling detector.
// Included by the top level; depends on nothing else.
`ifndef POSE_SETTLING_DETECTOR_DEFINES_SVH
`define POSE_SETTLING_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("psd implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define PSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("psd next-cycle check failed");

`endif

// ===== sv/psd_pkg.sv =====
// Shared constants and types for the pose settling detector.
// No dependencies; used by psd_axis and pose_settling_detector.
`default_nettype none

package psd_pkg;

	// Default averaging window, in samples
	localparam int WINDOW_DEF = 20;

	// Field widths
	localparam int POS_W = 32;
	localparam int THR_W = 24;

	// Threshold after reset, Q8.24 units (about 1e-6)
	localparam logic [THR_W-1:0] THR_RESET = 24'd17;

	// Per-transaction control from the top level to each axis lane
	typedef struct packed {
		logic shift;  // transaction accepted: store sample, update sum
		logic drop;   // window already full: remove the oldest sample
	} psd_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/psd_axis.sv =====
// One axis lane: delay line, running sum and mean-deviation test.
// Depends on psd_pkg.
`default_nettype none

module psd_axis #(
	parameter int WINDOW = psd_pkg::WINDOW_DEF,
	parameter int SUM_W  = psd_pkg::POS_W + $clog2(WINDOW),
	parameter int LIM_W  = psd_pkg::THR_W + $clog2(WINDOW + 1)
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire psd_pkg::psd_ctrl_t           ctrl,
	input  wire logic signed [psd_pkg::POS_W-1:0] sample,
	input  wire logic [LIM_W-1:0]             limit,
	output logic                              in_range
);

	localparam int DEV_W = SUM_W + 1;
	localparam logic signed [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);

	logic signed [psd_pkg::POS_W-1:0] hist_q [WINDOW];
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] scaled_s1;
	logic signed [SUM_W-1:0] scaled_d;
	logic signed [SUM_W-1:0] oldest;
	logic signed [DEV_W-1:0] dev;
	logic signed [DEV_W-1:0] lim_s;

	// Shift the delay line on each accepted transaction
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			hist_q[0] <= sample;
			for (int i = 1; i < WINDOW; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	// Drop the oldest sample once the window is full
	assign oldest = ctrl.drop ? SUM_W'(hist_q[WINDOW-1]) : '0;

	// Running sum of the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.shift) begin
			sum_q <= sum_q + SUM_W'(sample) - oldest;
		end
	end

	// Scale the new sample by the window length ahead of the test
	assign scaled_d = SUM_W'(sample) * WIN_S;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			scaled_s1 <= scaled_d;
		end
	end

	// Test |sum - WINDOW*sample| < WINDOW*threshold as two signed compares
	assign dev      = DEV_W'(sum_q) - DEV_W'(scaled_s1);
	assign lim_s    = $signed(DEV_W'(limit));
	assign in_range = (dev < lim_s) && (dev > -lim_s);

endmodule

`default_nettype wire

// ===== sv/pose_settling_detector.sv =====
// Top level of the pose settling detector: handshake, fill tracking, result register.
// Depends on psd_pkg, psd_axis and pose_settling_detector_defines.svh.
//
// Takes one x/y/z position sample (signed Q8.24) per transaction and returns one
// result per sample. Each sample passes through two register stages: the first
// stores it in the per-axis delay lines and updates the running sums, the second
// registers the result, so a result is offered once its sample has passed both stages,
// and a new sample can be taken every cycle unless out_stall holds back a full pipeline.
// stable goes high once WINDOW samples have arrived and every axis lies strictly within
// settle_threshold of its window mean; newly_stable marks the first stable result after
// a non-stable one. The threshold must be written through the cfg port (always ready)
// only while idle; the block does not enforce this. A zero threshold never reports stable.
`default_nettype none
`include "pose_settling_detector_defines.svh"

module pose_settling_detector #(
	parameter int WINDOW = psd_pkg::WINDOW_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// configuration write
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [psd_pkg::THR_W-1:0]       cfg_data,
	// sample input
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire logic signed [psd_pkg::POS_W-1:0] pos_x,
	input  wire logic signed [psd_pkg::POS_W-1:0] pos_y,
	input  wire logic signed [psd_pkg::POS_W-1:0] pos_z,
	// result output
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic                                 stable,
	output logic                                 newly_stable,
	output logic                                 window_full
);

	localparam int SUM_W  = psd_pkg::POS_W + $clog2(WINDOW);
	localparam int LIM_W  = psd_pkg::THR_W + $clog2(WINDOW + 1);
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);
	localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW - 1);
	localparam logic [LIM_W-1:0] WIN_L = LIM_W'(WINDOW);

	psd_pkg::psd_ctrl_t ctrl;
	logic               accept;
	logic               s1_valid_q;
	logic               full_s1;
	logic               s2_ready;
	logic               s1_advance;
	logic [FILL_W-1:0]  fill_q;
	logic [LIM_W-1:0]   limit_q;
	logic               was_stable_q;
	logic               in_range_x;
	logic               in_range_y;
	logic               in_range_z;
	logic               stable_now;

	// Threshold register, kept pre-scaled by the window length
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIM_W'(psd_pkg::THR_RESET) * WIN_L;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= LIM_W'(cfg_data) * WIN_L;
		end
	end

	// Pipeline handshake
	assign s2_ready   = !out_valid || !out_stall;
	assign s1_advance = s1_valid_q && s2_ready;
	assign in_stall   = s1_valid_q && !s2_ready;
	assign accept     = in_valid && !in_stall;

	assign ctrl.shift = accept;
	assign ctrl.drop  = (fill_q == FILL_MAX);

	// Fill count, saturating at the window length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept && (fill_q != FILL_MAX)) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	// Stage one valid and window-full flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			full_s1    <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				full_s1    <= (fill_q == FILL_MAX) || (fill_q == FILL_LAST);
			end else if (s1_advance) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// Axis lanes
	psd_axis #(.WINDOW(WINDOW), .SUM_W(SUM_W), .LIM_W(LIM_W)) u_axis_x (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .sample(pos_x),
		.limit(limit_q), .in_range(in_range_x)
	);

	psd_axis #(.WINDOW(WINDOW), .SUM_W(SUM_W), .LIM_W(LIM_W)) u_axis_y (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .sample(pos_y),
		.limit(limit_q), .in_range(in_range_y)
	);

	psd_axis #(.WINDOW(WINDOW), .SUM_W(SUM_W), .LIM_W(LIM_W)) u_axis_z (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .sample(pos_z),
		.limit(limit_q), .in_range(in_range_z)
	);

	assign stable_now = full_s1 && in_range_x && in_range_y && in_range_z;

	// Result register and previous-stable flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			was_stable_q <= 1'b0;
		end else begin
			if (s1_advance) begin
				out_valid    <= 1'b1;
				was_stable_q <= stable_now;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			stable       <= stable_now;
			newly_stable <= stable_now && !was_stable_q;
			window_full  <= full_s1;
		end
	end

	// Checks
	`PSD_ASSERT_IMPLY(a_stable_needs_full, clk, arst_n, out_valid && stable, window_full)
	`PSD_ASSERT_IMPLY(a_rise_is_stable, clk, arst_n, out_valid && newly_stable, stable)
	`PSD_ASSERT_NEXT(a_fill_saturates, clk, arst_n, fill_q == FILL_MAX, fill_q == FILL_MAX)
	`PSD_ASSERT_IMPLY(a_stall_only_when_busy, clk, arst_n, in_stall, s1_valid_q && out_valid)

endmodule

`default_nettype wire
